// ----- rtl/i2cm_pkg.sv -----
package i2cm_pkg;

	localparam int DevAddrWidth = 7;
	localparam int StretchWidth = 16;
	localparam int HalfWidth = 10;
	localparam int AddrWidth = 4;
	localparam int BitsPerByte = 8;
	localparam int QueueDepth = 2;

	localparam logic [AddrWidth-1:0] RegDevAddr = 4'h0;
	localparam logic [AddrWidth-1:0] RegStretch = 4'h4;
	localparam logic [AddrWidth-1:0] RegHalf = 4'h8;
	localparam logic [AddrWidth-1:0] RegBurst = 4'hC;

	localparam logic [StretchWidth-1:0] StretchReset = 16'd1000;
	localparam logic [HalfWidth-1:0] HalfReset = 10'd1;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_TIMEOUT = 2'd1,
		ST_NACK = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		P_IDLE, P_ST_PRE, P_ST_WAIT, P_ST_HIGH, P_ST_FALL,
		P_TX_LOW, P_TX_WAIT, P_TX_HIGH, P_TA_LOW, P_TA_WAIT, P_TA_HIGH,
		P_RX_LOW, P_RX_WAIT, P_RX_HIGH, P_MA_LOW, P_MA_WAIT, P_MA_HIGH,
		P_HOLD, P_SP_LOW, P_SP_WAIT, P_SP_HIGH, P_SP_RISE
	} phase_t;

	typedef enum logic [2:0] {
		S_ADDR_W, S_REG, S_DATA, S_ADDR_R, S_READ, S_RESTART, S_END
	} step_t;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] reg_address;
		logic [7:0] write_data;
		logic burst_first;
		logic burst_last;
		logic scl_level;
		logic sda_level;
	} req_t;

	typedef struct packed {
		logic scl_release;
		logic sda_release;
		logic busy_res;
		logic done_res;
		logic [1:0] status;
		logic [7:0] read_data;
	} res_t;

	typedef struct packed {
		logic [DevAddrWidth-1:0] device_address;
		logic [StretchWidth-1:0] stretch_limit;
		logic [HalfWidth-1:0] half_period;
		logic burst_mode;
	} cfg_t;

	// Request after the front end has classified the command.
	typedef struct packed {
		logic start;
		logic rd;
		req_t req;
	} cls_t;

endpackage

// ----- rtl/i2cm_front.sv -----
module i2cm_front #(
	parameter int QUEUE_DEPTH = i2cm_pkg::QueueDepth
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input i2cm_pkg::req_t in_req,
	output logic q_valid,
	input logic q_pop,
	output i2cm_pkg::cls_t q_data
);

	localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	i2cm_pkg::cls_t mem_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [PtrW:0] cnt_q;
	i2cm_pkg::cls_t cls;
	logic push;

	always_comb begin
		cls.req = in_req;
		cls.start = (in_req.command == i2cm_pkg::CMD_WRITE) ||
			(in_req.command == i2cm_pkg::CMD_READ);
		cls.rd = (in_req.command == i2cm_pkg::CMD_READ);
	end

	assign in_stall = (cnt_q == (PtrW+1)'(QUEUE_DEPTH));
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != '0);
	assign q_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PtrW'(QUEUE_DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (q_pop) begin
				rd_q <= (rd_q == PtrW'(QUEUE_DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
		end
	end

endmodule

// ----- rtl/i2cm_engine.sv -----
module i2cm_engine (
	input logic clk,
	input logic arst_n,
	input i2cm_pkg::cfg_t cfg,
	input logic q_valid,
	output logic q_pop,
	input i2cm_pkg::cls_t q_data,
	output logic out_valid,
	input logic out_stall,
	output i2cm_pkg::res_t out_res
);

	i2cm_pkg::phase_t phase_q, phase_d;
	i2cm_pkg::step_t step_q, step_d;
	logic [3:0] bit_q, bit_d;
	logic [7:0] shift_q, shift_d;
	logic [15:0] str_q, str_d;
	logic [9:0] div_q, div_d;
	logic [7:0] haddr_q, haddr_d, hdata_q, hdata_d;
	logic hrd_q, hrd_d, hlast_q, hlast_d;
	logic intr_q, intr_d;
	logic [1:0] sth_q, sth_d;
	logic fin;
	logic [15:0] lim;
	logic [9:0] hp;
	logic [15:0] str_inc;
	logic [9:0] div_inc;
	logic [3:0] bit_inc;
	logic wait_ph, header, adv, go;
	logic scl_o, sda_o;
	logic [7:0] addr_w;
	i2cm_pkg::req_t r;
	i2cm_pkg::res_t res;

	assign go = q_valid && (!out_valid || !out_stall);
	assign q_pop = go;
	assign r = q_data.req;
	assign lim = (cfg.stretch_limit == '0) ? 16'd1 : cfg.stretch_limit;
	assign hp = (cfg.half_period == '0) ? 10'd1 : cfg.half_period;
	assign str_inc = str_q + 16'd1;
	assign div_inc = div_q + 10'd1;
	assign addr_w = {cfg.device_address, 1'b0};

	always_comb begin
		phase_d = phase_q; step_d = step_q; bit_d = bit_q; shift_d = shift_q;
		str_d = str_q; div_d = div_q; haddr_d = haddr_q; hdata_d = hdata_q;
		hrd_d = hrd_q; hlast_d = hlast_q; intr_d = intr_q; sth_d = sth_q;
		fin = 1'b0; adv = 1'b0; header = 1'b0; bit_inc = bit_q + 4'd1;
		wait_ph = (phase_q == i2cm_pkg::P_ST_WAIT) || (phase_q == i2cm_pkg::P_TX_WAIT) ||
			(phase_q == i2cm_pkg::P_TA_WAIT) || (phase_q == i2cm_pkg::P_RX_WAIT) ||
			(phase_q == i2cm_pkg::P_MA_WAIT) || (phase_q == i2cm_pkg::P_SP_WAIT);
		if (phase_q == i2cm_pkg::P_IDLE) begin
			if (q_data.start) begin
				header = !cfg.burst_mode || !intr_q || r.burst_first || (hrd_q != q_data.rd);
				haddr_d = r.reg_address;
				hdata_d = r.write_data;
				hrd_d = q_data.rd;
				hlast_d = !cfg.burst_mode || r.burst_last;
				sth_d = i2cm_pkg::ST_OK;
				bit_d = '0; str_d = '0; div_d = '0;
				if (header) begin
					step_d = i2cm_pkg::S_ADDR_W;
					shift_d = addr_w;
					phase_d = intr_q ? i2cm_pkg::P_ST_PRE : i2cm_pkg::P_ST_WAIT;
				end else if (q_data.rd) begin
					step_d = i2cm_pkg::S_READ;
					shift_d = '0;
					phase_d = i2cm_pkg::P_RX_LOW;
				end else begin
					step_d = i2cm_pkg::S_DATA;
					shift_d = r.write_data;
					phase_d = i2cm_pkg::P_TX_LOW;
				end
			end
		end else if (wait_ph) begin
			if (r.scl_level) begin
				adv = 1'b1;
			end else begin
				str_d = str_inc;
				if (str_inc >= lim) begin
					div_d = '0; str_d = '0;
					if (phase_q == i2cm_pkg::P_SP_WAIT) begin
						if (sth_q == i2cm_pkg::ST_OK) sth_d = i2cm_pkg::ST_TIMEOUT;
						phase_d = i2cm_pkg::P_SP_RISE;
					end else begin
						if (sth_q == i2cm_pkg::ST_OK) sth_d = i2cm_pkg::ST_TIMEOUT;
						step_d = i2cm_pkg::S_END;
						phase_d = i2cm_pkg::P_SP_LOW;
					end
				end
			end
		end else begin
			div_d = div_inc;
			if (div_inc >= hp) adv = 1'b1;
		end
		if (adv) begin
			div_d = '0; str_d = '0;
			case (phase_q)
				i2cm_pkg::P_ST_PRE: phase_d = i2cm_pkg::P_ST_WAIT;
				i2cm_pkg::P_ST_WAIT: phase_d = i2cm_pkg::P_ST_HIGH;
				i2cm_pkg::P_ST_HIGH: phase_d = i2cm_pkg::P_ST_FALL;
				i2cm_pkg::P_ST_FALL: phase_d = i2cm_pkg::P_TX_LOW;
				i2cm_pkg::P_TX_LOW: phase_d = i2cm_pkg::P_TX_WAIT;
				i2cm_pkg::P_TX_WAIT: phase_d = i2cm_pkg::P_TX_HIGH;
				i2cm_pkg::P_TX_HIGH: begin
					shift_d = {shift_q[6:0], 1'b0};
					bit_d = bit_inc;
					phase_d = (bit_inc >= 4'(i2cm_pkg::BitsPerByte)) ?
						i2cm_pkg::P_TA_LOW : i2cm_pkg::P_TX_LOW;
				end
				i2cm_pkg::P_TA_LOW: phase_d = i2cm_pkg::P_TA_WAIT;
				i2cm_pkg::P_TA_WAIT: begin
					if (r.sda_level) begin
						if (sth_q == i2cm_pkg::ST_OK) sth_d = i2cm_pkg::ST_NACK;
						step_d = i2cm_pkg::S_END;
						phase_d = i2cm_pkg::P_SP_LOW;
					end else begin
						phase_d = i2cm_pkg::P_TA_HIGH;
					end
				end
				i2cm_pkg::P_TA_HIGH: begin
					case (step_q)
						i2cm_pkg::S_ADDR_W: begin
							step_d = i2cm_pkg::S_REG;
							shift_d = haddr_q; bit_d = '0;
							phase_d = i2cm_pkg::P_TX_LOW;
						end
						i2cm_pkg::S_REG: begin
							if (hrd_q) begin
								step_d = i2cm_pkg::S_RESTART;
								phase_d = i2cm_pkg::P_SP_LOW;
							end else begin
								step_d = i2cm_pkg::S_DATA;
								shift_d = hdata_q; bit_d = '0;
								phase_d = i2cm_pkg::P_TX_LOW;
							end
						end
						i2cm_pkg::S_DATA: begin
							if (hlast_q) begin
								step_d = i2cm_pkg::S_END;
								phase_d = i2cm_pkg::P_SP_LOW;
							end else begin
								phase_d = i2cm_pkg::P_HOLD;
							end
						end
						i2cm_pkg::S_ADDR_R: begin
							step_d = i2cm_pkg::S_READ;
							shift_d = '0; bit_d = '0;
							phase_d = i2cm_pkg::P_RX_LOW;
						end
						default: begin
							step_d = i2cm_pkg::S_END;
							phase_d = i2cm_pkg::P_SP_LOW;
						end
					endcase
				end
				i2cm_pkg::P_RX_LOW: phase_d = i2cm_pkg::P_RX_WAIT;
				i2cm_pkg::P_RX_WAIT: begin
					shift_d = {shift_q[6:0], r.sda_level};
					phase_d = i2cm_pkg::P_RX_HIGH;
				end
				i2cm_pkg::P_RX_HIGH: begin
					bit_d = bit_inc;
					phase_d = (bit_inc >= 4'(i2cm_pkg::BitsPerByte)) ?
						i2cm_pkg::P_MA_LOW : i2cm_pkg::P_RX_LOW;
				end
				i2cm_pkg::P_MA_LOW: phase_d = i2cm_pkg::P_MA_WAIT;
				i2cm_pkg::P_MA_WAIT: phase_d = i2cm_pkg::P_MA_HIGH;
				i2cm_pkg::P_MA_HIGH: begin
					if (hlast_q) begin
						step_d = i2cm_pkg::S_END;
						phase_d = i2cm_pkg::P_SP_LOW;
					end else begin
						phase_d = i2cm_pkg::P_HOLD;
					end
				end
				i2cm_pkg::P_HOLD: begin
					phase_d = i2cm_pkg::P_IDLE; intr_d = 1'b1; fin = 1'b1;
				end
				i2cm_pkg::P_SP_LOW: phase_d = i2cm_pkg::P_SP_WAIT;
				i2cm_pkg::P_SP_WAIT: phase_d = i2cm_pkg::P_SP_HIGH;
				i2cm_pkg::P_SP_HIGH: phase_d = i2cm_pkg::P_SP_RISE;
				i2cm_pkg::P_SP_RISE: begin
					if (step_q == i2cm_pkg::S_RESTART) begin
						step_d = i2cm_pkg::S_ADDR_R;
						shift_d = {cfg.device_address, 1'b1}; bit_d = '0;
						phase_d = i2cm_pkg::P_ST_WAIT;
					end else begin
						phase_d = i2cm_pkg::P_IDLE; intr_d = 1'b0; fin = 1'b1;
					end
				end
				default: begin
					phase_d = i2cm_pkg::P_IDLE; intr_d = 1'b0; fin = 1'b1;
				end
			endcase
		end

		case (phase_d)
			i2cm_pkg::P_IDLE: begin scl_o = !intr_d; sda_o = 1'b1; end
			i2cm_pkg::P_ST_PRE, i2cm_pkg::P_HOLD, i2cm_pkg::P_TA_LOW,
			i2cm_pkg::P_RX_LOW: begin scl_o = 1'b0; sda_o = 1'b1; end
			i2cm_pkg::P_ST_FALL, i2cm_pkg::P_SP_WAIT,
			i2cm_pkg::P_SP_HIGH: begin scl_o = 1'b1; sda_o = 1'b0; end
			i2cm_pkg::P_TX_LOW: begin scl_o = 1'b0; sda_o = shift_d[7]; end
			i2cm_pkg::P_TX_WAIT,
			i2cm_pkg::P_TX_HIGH: begin scl_o = 1'b1; sda_o = shift_d[7]; end
			i2cm_pkg::P_MA_LOW: begin scl_o = 1'b0; sda_o = hlast_d; end
			i2cm_pkg::P_MA_WAIT,
			i2cm_pkg::P_MA_HIGH: begin scl_o = 1'b1; sda_o = hlast_d; end
			i2cm_pkg::P_SP_LOW: begin scl_o = 1'b0; sda_o = 1'b0; end
			default: begin scl_o = 1'b1; sda_o = 1'b1; end
		endcase
		res.scl_release = scl_o;
		res.sda_release = sda_o;
		res.busy_res = (phase_d != i2cm_pkg::P_IDLE);
		res.done_res = fin;
		res.status = fin ? sth_d : 2'd0;
		res.read_data = (fin && hrd_d && sth_d == i2cm_pkg::ST_OK) ? shift_d : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cm_pkg::P_IDLE;
			step_q <= i2cm_pkg::S_ADDR_W;
			bit_q <= '0; shift_q <= '0; str_q <= '0; div_q <= '0;
			haddr_q <= '0; hdata_q <= '0; hrd_q <= 1'b0; hlast_q <= 1'b0;
			intr_q <= 1'b0; sth_q <= i2cm_pkg::ST_OK;
			out_valid <= 1'b0;
		end else begin
			if (go) begin
				phase_q <= phase_d; step_q <= step_d; bit_q <= bit_d;
				shift_q <= shift_d; str_q <= str_d; div_q <= div_d;
				haddr_q <= haddr_d; hdata_q <= hdata_d; hrd_q <= hrd_d;
				hlast_q <= hlast_d; intr_q <= intr_d; sth_q <= sth_d;
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			out_res <= res;
		end
	end

endmodule

// ----- rtl/i2cm_regs.sv -----
module i2cm_regs (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [i2cm_pkg::AddrWidth-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output i2cm_pkg::cfg_t cfg
);

	i2cm_pkg::cfg_t cfg_q;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address <= '0;
			cfg_q.stretch_limit <= i2cm_pkg::StretchReset;
			cfg_q.half_period <= i2cm_pkg::HalfReset;
			cfg_q.burst_mode <= 1'b0;
		end else if (wr) begin
			case (paddr)
				i2cm_pkg::RegDevAddr: cfg_q.device_address <= pwdata[6:0];
				i2cm_pkg::RegStretch: cfg_q.stretch_limit <= pwdata[15:0];
				i2cm_pkg::RegHalf: cfg_q.half_period <= pwdata[9:0];
				i2cm_pkg::RegBurst: cfg_q.burst_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			i2cm_pkg::RegDevAddr: prdata = {25'd0, cfg_q.device_address};
			i2cm_pkg::RegStretch: prdata = {16'd0, cfg_q.stretch_limit};
			i2cm_pkg::RegHalf: prdata = {22'd0, cfg_q.half_period};
			i2cm_pkg::RegBurst: prdata = {31'd0, cfg_q.burst_mode};
			default: prdata = '0;
		endcase
	end

endmodule

// ----- rtl/i2c_master_register_access.sv -----
// Channel  Direction  Payload  Handshake
// in       input      req_t    in_valid / in_stall
// out      output     res_t    out_valid / out_stall
// One request per cycle while in_stall is low; each request is one bus tick and gives one result.
// A request is written into the queue and then taken by the bus engine, whose
// result is registered at the edge on which the engine pops it from the queue.
// Reset idles the bus with both lines released and loads the register defaults.
// A stalled output holds the engine; the two-entry queue then fills and stalls input.
module i2c_master_register_access #(
	parameter int QUEUE_DEPTH = i2cm_pkg::QueueDepth
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input i2cm_pkg::req_t in_req,
	output logic out_valid,
	input logic out_stall,
	output i2cm_pkg::res_t out_res,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [i2cm_pkg::AddrWidth-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	i2cm_pkg::cfg_t cfg;
	i2cm_pkg::cls_t q_data;
	logic q_valid, q_pop;

	i2cm_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	i2cm_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_req, .q_valid, .q_pop, .q_data
	);

	i2cm_engine u_engine (
		.clk, .arst_n, .cfg, .q_valid, .q_pop, .q_data, .out_valid, .out_stall, .out_res
	);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_res))
		else $error("result changed under stall");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_res.done_res |-> !out_res.busy_res)
		else $error("done while busy");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

endmodule

// ----- tb/tb_i2c_master_register_access.sv -----
`timescale 1ns / 100ps

module tb_i2c_master_register_access;

	localparam int CycleLimit = 400000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	i2cm_pkg::req_t in_req;
	logic out_valid;
	logic out_stall;
	i2cm_pkg::res_t out_res;
	logic psel;
	logic penable;
	logic pwrite;
	logic [i2cm_pkg::AddrWidth-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	i2c_master_register_access dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_req(in_req),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_res(out_res),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Bus engine mirror.
	logic [6:0] dev_addr;
	logic [15:0] str_lim;
	logic [9:0] half_per;
	logic burst_on;
	i2cm_pkg::phase_t ph;
	i2cm_pkg::step_t seq;
	i2cm_pkg::status_t hold_st;
	logic [3:0] bit_cnt;
	logic [7:0] shreg;
	logic [15:0] low_cnt;
	logic [9:0] div_cnt;
	logic [7:0] h_addr;
	logic [7:0] h_data;
	logic f_read;
	logic f_last;
	logic bus_held;
	logic fin;

	i2cm_pkg::res_t pending_results[$];
	int mismatches = 0;
	int cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int scl_low_pct = 10;
	bit last_dir = 0;

	function automatic void go(i2cm_pkg::phase_t p);
		ph = p;
		div_cnt = '0;
		low_cnt = '0;
	endfunction

	function automatic void load_byte(logic [7:0] b, i2cm_pkg::phase_t p);
		shreg = b;
		bit_cnt = '0;
		go(p);
	endfunction

	function automatic void stop_seq(i2cm_pkg::step_t s);
		seq = s;
		go(i2cm_pkg::P_SP_LOW);
	endfunction

	function automatic void abort_xfer(i2cm_pkg::status_t c);
		if (hold_st == i2cm_pkg::ST_OK) begin
			hold_st = c;
		end
		stop_seq(i2cm_pkg::S_END);
	endfunction

	function automatic void wrap_up(logic h);
		go(i2cm_pkg::P_IDLE);
		bus_held = h;
		fin = 1'b1;
	endfunction

	function automatic void data_done();
		if (f_last) begin
			stop_seq(i2cm_pkg::S_END);
		end else begin
			go(i2cm_pkg::P_HOLD);
		end
	endfunction

	function automatic void after_ack();
		case (seq)
			i2cm_pkg::S_ADDR_W: begin
				seq = i2cm_pkg::S_REG;
				load_byte(h_addr, i2cm_pkg::P_TX_LOW);
			end
			i2cm_pkg::S_REG: begin
				if (f_read) begin
					stop_seq(i2cm_pkg::S_RESTART);
				end else begin
					seq = i2cm_pkg::S_DATA;
					load_byte(h_data, i2cm_pkg::P_TX_LOW);
				end
			end
			i2cm_pkg::S_DATA: data_done();
			i2cm_pkg::S_ADDR_R: begin
				seq = i2cm_pkg::S_READ;
				load_byte(8'h00, i2cm_pkg::P_RX_LOW);
			end
			default: stop_seq(i2cm_pkg::S_END);
		endcase
	endfunction

	function automatic void advance(logic sda);
		case (ph)
			i2cm_pkg::P_ST_PRE: go(i2cm_pkg::P_ST_WAIT);
			i2cm_pkg::P_ST_WAIT: go(i2cm_pkg::P_ST_HIGH);
			i2cm_pkg::P_ST_HIGH: go(i2cm_pkg::P_ST_FALL);
			i2cm_pkg::P_ST_FALL: go(i2cm_pkg::P_TX_LOW);
			i2cm_pkg::P_TX_LOW: go(i2cm_pkg::P_TX_WAIT);
			i2cm_pkg::P_TX_WAIT: go(i2cm_pkg::P_TX_HIGH);
			i2cm_pkg::P_TX_HIGH: begin
				shreg = shreg << 1;
				bit_cnt = bit_cnt + 4'd1;
				go(bit_cnt >= i2cm_pkg::BitsPerByte ? i2cm_pkg::P_TA_LOW : i2cm_pkg::P_TX_LOW);
			end
			i2cm_pkg::P_TA_LOW: go(i2cm_pkg::P_TA_WAIT);
			i2cm_pkg::P_TA_WAIT: begin
				if (sda) begin
					abort_xfer(i2cm_pkg::ST_NACK);
				end else begin
					go(i2cm_pkg::P_TA_HIGH);
				end
			end
			i2cm_pkg::P_TA_HIGH: after_ack();
			i2cm_pkg::P_RX_LOW: go(i2cm_pkg::P_RX_WAIT);
			i2cm_pkg::P_RX_WAIT: begin
				shreg = {shreg[6:0], sda};
				go(i2cm_pkg::P_RX_HIGH);
			end
			i2cm_pkg::P_RX_HIGH: begin
				bit_cnt = bit_cnt + 4'd1;
				go(bit_cnt >= i2cm_pkg::BitsPerByte ? i2cm_pkg::P_MA_LOW : i2cm_pkg::P_RX_LOW);
			end
			i2cm_pkg::P_MA_LOW: go(i2cm_pkg::P_MA_WAIT);
			i2cm_pkg::P_MA_WAIT: go(i2cm_pkg::P_MA_HIGH);
			i2cm_pkg::P_MA_HIGH: data_done();
			i2cm_pkg::P_HOLD: wrap_up(1'b1);
			i2cm_pkg::P_SP_LOW: go(i2cm_pkg::P_SP_WAIT);
			i2cm_pkg::P_SP_WAIT: go(i2cm_pkg::P_SP_HIGH);
			i2cm_pkg::P_SP_HIGH: go(i2cm_pkg::P_SP_RISE);
			i2cm_pkg::P_SP_RISE: begin
				if (seq == i2cm_pkg::S_RESTART) begin
					seq = i2cm_pkg::S_ADDR_R;
					load_byte({dev_addr, 1'b1}, i2cm_pkg::P_ST_WAIT);
				end else begin
					wrap_up(1'b0);
				end
			end
			default: wrap_up(1'b0);
		endcase
	endfunction

	function automatic bit waits_for_scl(i2cm_pkg::phase_t p);
		return p == i2cm_pkg::P_ST_WAIT || p == i2cm_pkg::P_TX_WAIT ||
			p == i2cm_pkg::P_TA_WAIT || p == i2cm_pkg::P_RX_WAIT ||
			p == i2cm_pkg::P_MA_WAIT || p == i2cm_pkg::P_SP_WAIT;
	endfunction

	function automatic i2cm_pkg::res_t bus_tick(i2cm_pkg::req_t r);
		i2cm_pkg::res_t o;
		logic rd;
		logic hdr;
		logic [9:0] hp;
		logic [15:0] lim;
		hp = (half_per == 0) ? 10'd1 : half_per;
		lim = (str_lim == 0) ? 16'd1 : str_lim;
		fin = 1'b0;
		if (ph == i2cm_pkg::P_IDLE) begin
			if (r.command == i2cm_pkg::CMD_WRITE || r.command == i2cm_pkg::CMD_READ) begin
				rd = (r.command == i2cm_pkg::CMD_READ);
				hdr = !burst_on || !bus_held || r.burst_first || (f_read != rd);
				f_read = rd;
				f_last = !burst_on || r.burst_last;
				h_addr = r.reg_address;
				h_data = r.write_data;
				hold_st = i2cm_pkg::ST_OK;
				if (hdr) begin
					seq = i2cm_pkg::S_ADDR_W;
					load_byte({dev_addr, 1'b0},
						bus_held ? i2cm_pkg::P_ST_PRE : i2cm_pkg::P_ST_WAIT);
				end else if (rd) begin
					seq = i2cm_pkg::S_READ;
					load_byte(8'h00, i2cm_pkg::P_RX_LOW);
				end else begin
					seq = i2cm_pkg::S_DATA;
					load_byte(h_data, i2cm_pkg::P_TX_LOW);
				end
			end
		end else if (waits_for_scl(ph)) begin
			if (r.scl_level) begin
				advance(r.sda_level);
			end else begin
				low_cnt = low_cnt + 16'd1;
				if (low_cnt >= lim) begin
					if (ph == i2cm_pkg::P_SP_WAIT) begin
						if (hold_st == i2cm_pkg::ST_OK) begin
							hold_st = i2cm_pkg::ST_TIMEOUT;
						end
						go(i2cm_pkg::P_SP_RISE);
					end else begin
						abort_xfer(i2cm_pkg::ST_TIMEOUT);
					end
				end
			end
		end else begin
			div_cnt = div_cnt + 10'd1;
			if (div_cnt >= hp) begin
				advance(r.sda_level);
			end
		end
		case (ph)
			i2cm_pkg::P_IDLE: begin
				o.scl_release = !bus_held;
				o.sda_release = 1'b1;
			end
			i2cm_pkg::P_ST_PRE, i2cm_pkg::P_HOLD, i2cm_pkg::P_TA_LOW,
			i2cm_pkg::P_RX_LOW: begin
				o.scl_release = 1'b0;
				o.sda_release = 1'b1;
			end
			i2cm_pkg::P_ST_FALL, i2cm_pkg::P_SP_WAIT, i2cm_pkg::P_SP_HIGH: begin
				o.scl_release = 1'b1;
				o.sda_release = 1'b0;
			end
			i2cm_pkg::P_TX_LOW: begin
				o.scl_release = 1'b0;
				o.sda_release = shreg[7];
			end
			i2cm_pkg::P_TX_WAIT, i2cm_pkg::P_TX_HIGH: begin
				o.scl_release = 1'b1;
				o.sda_release = shreg[7];
			end
			i2cm_pkg::P_MA_LOW: begin
				o.scl_release = 1'b0;
				o.sda_release = f_last;
			end
			i2cm_pkg::P_MA_WAIT, i2cm_pkg::P_MA_HIGH: begin
				o.scl_release = 1'b1;
				o.sda_release = f_last;
			end
			i2cm_pkg::P_SP_LOW: begin
				o.scl_release = 1'b0;
				o.sda_release = 1'b0;
			end
			default: begin
				o.scl_release = 1'b1;
				o.sda_release = 1'b1;
			end
		endcase
		o.busy_res = (ph != i2cm_pkg::P_IDLE);
		o.done_res = fin;
		o.status = fin ? hold_st : i2cm_pkg::ST_OK;
		o.read_data = (fin && f_read && hold_st == i2cm_pkg::ST_OK) ? shreg : 8'h00;
		return o;
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("tb_i2c_master_register_access: FAIL");
			$finish;
		end
	end

	task automatic field_check(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch %s: expected %0d, got %0d", name, exp_v, act_v);
			end
		end
	endtask

	always @(posedge clk) begin
		i2cm_pkg::res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result %h", out_res);
				end
			end else begin
				e = pending_results.pop_front();
				field_check("scl_release", int'(e.scl_release), int'(out_res.scl_release));
				field_check("sda_release", int'(e.sda_release), int'(out_res.sda_release));
				field_check("busy_res", int'(e.busy_res), int'(out_res.busy_res));
				field_check("done_res", int'(e.done_res), int'(out_res.done_res));
				field_check("status", int'(e.status), int'(out_res.status));
				field_check("read_data", int'(e.read_data), int'(out_res.read_data));
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic send_tick(i2cm_pkg::req_t r);
		in_valid <= 1'b1;
		in_req <= r;
		do begin
			@(posedge clk);
		end while (in_stall);
		pending_results.push_back(bus_tick(r));
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			while ($urandom_range(99) < idle_pct) begin
				@(posedge clk);
			end
			@(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (6) @(posedge clk);
	endtask

	task automatic reg_write(logic [i2cm_pkg::AddrWidth-1:0] a, logic [31:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= a;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (a)
			i2cm_pkg::RegDevAddr: dev_addr = v[6:0];
			i2cm_pkg::RegStretch: str_lim = v[15:0];
			i2cm_pkg::RegHalf: half_per = v[9:0];
			default: burst_on = v[0];
		endcase
	endtask

	task automatic set_config(logic [6:0] da, logic [15:0] sl, logic [9:0] hp, logic bm);
		drain();
		reg_write(i2cm_pkg::RegDevAddr, 32'(da));
		reg_write(i2cm_pkg::RegStretch, 32'(sl));
		reg_write(i2cm_pkg::RegHalf, 32'(hp));
		reg_write(i2cm_pkg::RegBurst, 32'(bm));
	endtask

	// The device side acknowledges most bytes; SCL is held low now and then.
	function automatic i2cm_pkg::req_t next_tick();
		i2cm_pkg::req_t r;
		r.reg_address = 8'($urandom_range(255));
		r.write_data = 8'($urandom_range(255));
		r.burst_first = ($urandom_range(99) < 25);
		r.burst_last = ($urandom_range(99) < 30);
		r.scl_level = !($urandom_range(99) < scl_low_pct);
		r.sda_level = (ph == i2cm_pkg::P_TA_WAIT) ? ($urandom_range(99) < 8) :
			1'($urandom_range(1));
		if (ph == i2cm_pkg::P_IDLE && $urandom_range(99) < 60) begin
			if ($urandom_range(99) < 25) begin
				last_dir = !last_dir;
			end
			r.command = last_dir ? i2cm_pkg::CMD_READ : i2cm_pkg::CMD_WRITE;
		end else begin
			r.command = 2'($urandom_range(3));
		end
		return r;
	endfunction

	task automatic run_traffic(int n);
		repeat (n) send_tick(next_tick());
	endtask

	task automatic test_directed();
		i2cm_pkg::req_t r;
		set_config(7'h7F, 16'hFFFF, 10'd1, 1'b0);
		r = '{command: i2cm_pkg::CMD_WRITE, reg_address: 8'hFF, write_data: 8'hFF,
			burst_first: 1'b1, burst_last: 1'b1, scl_level: 1'b1, sda_level: 1'b0};
		send_tick(r);
		r.command = 2'd3;
		send_tick(r);
		r.command = i2cm_pkg::CMD_READ;
		r.reg_address = 8'h00;
		r.write_data = 8'h00;
		send_tick(r);
		r.command = i2cm_pkg::CMD_TICK;
		repeat (20) send_tick(r);
	endtask

	task automatic test_single_no_idle();
		idle_pct = 0;
		stall_pct = 0;
		scl_low_pct = 5;
		set_config(7'h00, 16'd1000, 10'd1, 1'b0);
		run_traffic(80);
		drain();
		run_traffic(70);
	endtask

	task automatic test_burst_sender_idle();
		idle_pct = 76;
		stall_pct = 0;
		scl_low_pct = 10;
		set_config(7'h55, 16'd3, 10'd2, 1'b1);
		run_traffic(150);
	endtask

	task automatic test_burst_receiver_stall();
		idle_pct = 0;
		stall_pct = 76;
		scl_low_pct = 10;
		set_config(7'h2A, 16'd1, 10'd1, 1'b1);
		run_traffic(100);
		set_config(7'h13, 16'd0, 10'd0, 1'b1);
		run_traffic(50);
	endtask

	task automatic test_both_idle();
		idle_pct = 17;
		stall_pct = 17;
		scl_low_pct = 8;
		set_config(7'h6C, 16'd2, 10'd1023, 1'b0);
		run_traffic(30);
		set_config(7'h31, 16'd5, 10'd1, 1'b1);
		run_traffic(90);
		set_config(7'h4E, 16'd1000, 10'd1, 1'b0);
		run_traffic(30);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_req = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		dev_addr = '0;
		str_lim = i2cm_pkg::StretchReset;
		half_per = i2cm_pkg::HalfReset;
		burst_on = 1'b0;
		ph = i2cm_pkg::P_IDLE;
		seq = i2cm_pkg::S_ADDR_W;
		hold_st = i2cm_pkg::ST_OK;
		bit_cnt = '0;
		shreg = '0;
		low_cnt = '0;
		div_cnt = '0;
		h_addr = '0;
		h_data = '0;
		f_read = 1'b0;
		f_last = 1'b0;
		bus_held = 1'b0;
		fin = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_single_no_idle();
		test_burst_sender_idle();
		test_burst_receiver_stall();
		test_both_idle();
		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_i2c_master_register_access: PASS");
		end else begin
			$display("tb_i2c_master_register_access: FAIL");
		end
		$finish;
	end

endmodule
